>>> sv/assert_macros.svh
// Assertion macros for the fan tachometer speed meter.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define FTRMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define FTRMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/ftrma_pkg.sv
// Package for the fan tachometer speed meter: widths, register indexes,
// reset values and the command and status types. No dependencies.
`default_nettype none

package ftrma_pkg;

  localparam int DivW       = 32;
  localparam int SpeedW     = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 32;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 24;
  localparam int WindowSizeDefault = 30;

  localparam logic [CfgIdxW-1:0] RegRateNum  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUpperLim = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLowerLim = 2'd2;

  localparam logic [DivW-1:0]   RateNumReset  = 32'd750000000;
  localparam logic [SpeedW-1:0] UpperLimReset = 16'd3300;
  localparam logic [SpeedW-1:0] LowerLimReset = 16'd50;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic check;
    logic mul;
    logic avg;
    logic load_out;
  } ftrma_cmd_t;

  typedef struct packed {
    logic start_div;
    logic div_done;
    logic in_range;
  } ftrma_sts_t;

endpackage

`default_nettype wire

>>> sv/fan_tacho_rpm_moving_average_top.sv
// Top level of the fan tachometer speed meter with moving average.
// Depends on ftrma_pkg, ftrma_ctrl, ftrma_datapath and assert_macros.svh.
//
//   Channel   Direction  Contents
//   in_       slave      tacho_level, counter_value
//   out_      master     average_rpm, edge_seen, reading_accepted
//   cfg_      write      rate_numerator, rpm_upper_limit, rpm_lower_limit
//
// A sample without an edge, or with a zero half period, goes from idle straight to
// the output load. An accepted edge is accepted, divided by the bit-serial divider,
// then updates the window, multiplies, forms the average and loads the output.
// A rejected edge goes from the range check straight to the output load. The output
// register holds a finished transaction while the next one is accepted; while it is
// still full, a finished transaction waits in the last state. Reset is synchronous and
// clears the window through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module fan_tacho_rpm_moving_average_top
  import ftrma_pkg::*;
#(
  parameter int WINDOW_SIZE = WindowSizeDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // [0] tacho_level, [32:1] counter_value, [39:33] zero
  input  wire logic [InDataW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [15:0] average_rpm, [16] edge_seen, [17] reading_accepted, [23:18] zero
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

`include "assert_macros.svh"

  ftrma_cmd_t        cmd;
  ftrma_sts_t        sts;
  logic [SpeedW-1:0] average_rpm;
  logic              edge_seen;
  logic              reading_accepted;

  ftrma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ftrma_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .tacho_level      (in_tdata[0]),
    .counter_value    (in_tdata[DivW:1]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .average_rpm      (average_rpm),
    .edge_seen        (edge_seen),
    .reading_accepted (reading_accepted)
  );

  assign out_tdata = {{(OutDataW - SpeedW - 2){1'b0}}, reading_accepted, edge_seen,
                      average_rpm};

  `FTRMA_ASSERT(a_one_at_a_time, (in_tvalid && in_tready) |=> !in_tready,
                "a second transaction was accepted while one was in progress")
  `FTRMA_ASSERT(a_load_when_free, cmd.load_out |-> (!out_tvalid || out_tready),
                "output register overwritten while still holding a transaction")
  `FTRMA_ASSERT(a_accept_needs_edge, out_tvalid |-> !(out_tdata[17] && !out_tdata[16]),
                "reading accepted on a sample without an edge")
  `FTRMA_ASSERT(a_div_start_idle, cmd.div_start |-> (cmd.accept && sts.start_div),
                "divider started outside an edge transaction")

endmodule

`default_nettype wire

>>> sv/ftrma_div.sv
// Restoring divider, one quotient bit per cycle, for the speed reading.
// Depends on ftrma_pkg.
`default_nettype none

module ftrma_div
  import ftrma_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DivW-1:0] dividend,
  input  wire logic [DivW-1:0] divisor,
  output logic                 done,
  output logic [DivW-1:0]      quotient
);

  localparam int CntW = $clog2(DivW);

  logic            busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DivW-1:0] quo_r, quo_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [DivW-1:0] den_r, den_nxt;
  logic [DivW:0]   rem_sh;
  logic [DivW:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign done     = busy_r && (cnt_r == CntW'(DivW - 1));
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (!rem_sub[DivW]) begin
        rem_nxt = rem_sub[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DivW-1:0];
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

`default_nettype wire

>>> sv/ftrma_datapath.sv
// Datapath: configuration registers, edge detection, divider, speed window
// memory, running sum, average and output data register. Depends on ftrma_pkg.
`default_nettype none

module ftrma_datapath
  import ftrma_pkg::*;
#(
  parameter int WINDOW_SIZE = WindowSizeDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ftrma_cmd_t          cmd,
  output ftrma_sts_t               sts,
  input  wire logic                tacho_level,
  input  wire logic [DivW-1:0]     counter_value,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output logic [SpeedW-1:0]        average_rpm,
  output logic                     edge_seen,
  output logic                     reading_accepted
);

  localparam int PtrW  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int LogW  = $clog2(WINDOW_SIZE);
  localparam int SumW  = SpeedW + LogW;
  localparam int Shift = SumW + LogW;
  localparam int RecW  = SumW + 1;
  localparam int ProdW = SumW + RecW;
  localparam logic [63:0] Recip = ((64'd1 << Shift) + 64'(WINDOW_SIZE) - 64'd1)
                                  / 64'(WINDOW_SIZE);

  logic [DivW-1:0]   rate_num_r;
  logic [SpeedW-1:0] upper_lim_r;
  logic [SpeedW-1:0] lower_lim_r;
  logic              last_level_r;
  logic [DivW-1:0]   last_edge_r;
  logic              edge_r;
  logic              acc_r;
  logic [PtrW-1:0]   ptr_r, ptr_nxt;
  logic [SumW-1:0]   sum_r;
  logic [ProdW-1:0]  prod_r;
  logic [SpeedW-1:0] avg_r;
  logic [WINDOW_SIZE-1:0] valid_r;
  logic [SpeedW-1:0] mem [WINDOW_SIZE];
  logic [SpeedW-1:0] rd_r;
  logic [SpeedW-1:0] old_speed;
  logic [SpeedW-1:0] avg_out_r;
  logic              edge_out_r;
  logic              acc_out_r;
  logic              edge_c;
  logic [DivW-1:0]   half_period;
  logic              div_done;
  logic [DivW-1:0]   quotient;
  logic [SpeedW-1:0] speed;
  logic              write_entry;

  assign edge_c      = tacho_level != last_level_r;
  assign half_period = counter_value - last_edge_r;
  assign speed       = quotient[SpeedW-1:0];
  assign old_speed   = valid_r[ptr_r] ? rd_r : '0;
  assign ptr_nxt     = (ptr_r == PtrW'(WINDOW_SIZE - 1)) ? '0 : ptr_r + 1'b1;

  assign sts.start_div = edge_c && (half_period != '0);
  assign sts.div_done  = div_done;
  assign sts.in_range  = (quotient < {{(DivW-SpeedW){1'b0}}, upper_lim_r}) &&
                         (quotient > {{(DivW-SpeedW){1'b0}}, lower_lim_r});
  assign write_entry   = cmd.check && sts.in_range;

  ftrma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rate_num_r),
    .divisor  (half_period),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_num_r  <= RateNumReset;
      upper_lim_r <= UpperLimReset;
      lower_lim_r <= LowerLimReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRateNum:  rate_num_r  <= cfg_wdata;
        RegUpperLim: upper_lim_r <= cfg_wdata[SpeedW-1:0];
        RegLowerLim: lower_lim_r <= cfg_wdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      last_edge_r  <= '0;
      ptr_r        <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
      valid_r      <= '0;
    end else begin
      if (cmd.accept && edge_c) begin
        last_level_r <= tacho_level;
        last_edge_r  <= counter_value;
      end
      if (write_entry) begin
        sum_r          <= sum_r - SumW'(old_speed) + SumW'(speed);
        valid_r[ptr_r] <= 1'b1;
        ptr_r          <= ptr_nxt;
      end
      if (cmd.avg) begin
        avg_r <= prod_r[Shift +: SpeedW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_entry) begin
      mem[ptr_r] <= speed;
    end
    rd_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      edge_r <= edge_c;
      acc_r  <= 1'b0;
    end else if (write_entry) begin
      acc_r <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= ProdW'(sum_r) * ProdW'(Recip[RecW-1:0]);
    end
    if (cmd.load_out) begin
      avg_out_r  <= avg_r;
      edge_out_r <= edge_r;
      acc_out_r  <= acc_r;
    end
  end

  assign average_rpm      = avg_out_r;
  assign edge_seen        = edge_out_r;
  assign reading_accepted = acc_out_r;

endmodule

`default_nettype wire

>>> sv/ftrma_ctrl.sv
// Controller state machine: sequences accept, division, window update,
// average and output load. Depends on ftrma_pkg.
`default_nettype none

module ftrma_ctrl
  import ftrma_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire ftrma_sts_t sts,
  output ftrma_cmd_t      cmd
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StAvg  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = state_r == StIdle;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      StIdle: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.start_div) begin
            cmd.div_start = 1'b1;
            state_nxt     = StDiv;
          end else begin
            state_nxt = StDone;
          end
        end
      end
      StDiv: begin
        if (sts.div_done) begin
          state_nxt = StChk;
        end
      end
      StChk: begin
        cmd.check = 1'b1;
        state_nxt = sts.in_range ? StMul : StDone;
      end
      StMul: begin
        cmd.mul   = 1'b1;
        state_nxt = StAvg;
      end
      StAvg: begin
        cmd.avg   = 1'b1;
        state_nxt = StDone;
      end
      StDone: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> test/fan_tacho_rpm_moving_average_top_test.sv
// Self-checking testbench for fan_tacho_rpm_moving_average_top: tachometer samples
// are streamed in and every averaged speed result is checked against a predictor.
// Depends on ftrma_pkg and the fan_tacho_rpm_moving_average_top RTL only.
`timescale 1ns / 100ps

module fan_tacho_rpm_moving_average_top_test;
  import ftrma_pkg::*;

  localparam int WINDOW_SIZE = WindowSizeDefault;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  typedef struct packed {
    logic              accepted;
    logic              edge_flag;
    logic [SpeedW-1:0] avg;
  } rpm_result_t;

  class rpm_scoreboard;
    logic [DivW-1:0]   rate_num;
    logic [SpeedW-1:0] upper;
    logic [SpeedW-1:0] lower;
    logic              level_q;
    logic [DivW-1:0]   edge_count_q;
    logic [SpeedW-1:0] speed_hist [WINDOW_SIZE];
    int                ptr;
    logic [20:0]       sum;
    logic [SpeedW-1:0] avg;
    rpm_result_t       pending [$];
    int samples, edges, accepts, results, errors;

    function new();
      rate_num     = RateNumReset;
      upper        = UpperLimReset;
      lower        = LowerLimReset;
      level_q      = 1'b0;
      edge_count_q = '0;
      foreach (speed_hist[i]) speed_hist[i] = '0;
      ptr     = 0;
      sum     = '0;
      avg     = '0;
      samples = 0;
      edges   = 0;
      accepts = 0;
      results = 0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegRateNum:  rate_num = val;
        RegUpperLim: upper = val[SpeedW-1:0];
        RegLowerLim: lower = val[SpeedW-1:0];
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function void note_sample(logic lvl, logic [DivW-1:0] cnt);
      logic [DivW-1:0] half;
      logic [DivW-1:0] speed;
      rpm_result_t     r;
      r = '0;
      samples++;
      if (lvl != level_q) begin
        half = cnt - edge_count_q;
        r.edge_flag = 1'b1;
        level_q = lvl;
        edge_count_q = cnt;
        edges++;
        // A zero half period would divide by zero, so it is simply rejected.
        if (half != '0) begin
          speed = rate_num / half;
          if (speed < {16'h0, upper} && speed > {16'h0, lower}) begin
            sum = sum - 21'(speed_hist[ptr]) + 21'(speed[SpeedW-1:0]);
            speed_hist[ptr] = speed[SpeedW-1:0];
            ptr = (ptr == WINDOW_SIZE - 1) ? 0 : ptr + 1;
            avg = 16'(sum / WINDOW_SIZE);
            r.accepted = 1'b1;
            accepts++;
          end
        end
      end
      r.avg = avg;
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [SpeedW-1:0] want, logic [SpeedW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      rpm_result_t got;
      rpm_result_t want;
      got = data[17:0];
      results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
        return;
      end
      want = pending.pop_front();
      compare_field("average_rpm", want.avg, got.avg);
      compare_field("edge_seen", 16'(want.edge_flag), 16'(got.edge_flag));
      compare_field("reading_accepted", 16'(want.accepted), 16'(got.accepted));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  rpm_scoreboard   board = new();
  logic            stim_level = 1'b0;
  logic [DivW-1:0] stim_edge = '0;
  int              sent = 0;
  int              settings = 0;

  fan_tacho_rpm_moving_average_top #(
    .WINDOW_SIZE(WINDOW_SIZE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic lvl, input logic [DivW-1:0] cnt);
    int gap;
    // Every third stretch of forty transactions goes out back to back.
    gap = ((sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, cnt, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_sample(lvl, cnt);
    sent++;
  endtask

  task automatic send_edge(input logic [DivW-1:0] half);
    stim_level = ~stim_level;
    stim_edge  = stim_edge + half;
    send_sample(stim_level, stim_edge);
  endtask

  task automatic send_flat(input logic [DivW-1:0] cnt);
    send_sample(stim_level, cnt);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_count() != 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic configure(input logic [DivW-1:0] num, input logic [SpeedW-1:0] up,
                           input logic [SpeedW-1:0] lo, input bit spare);
    wait_idle();
    cfg_write(RegRateNum, num);
    cfg_write(RegUpperLim, {16'($urandom), up});
    cfg_write(RegLowerLim, {16'($urandom), lo});
    if (spare) cfg_write(RegSpare, $urandom);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_directed();
    send_flat(32'h0000_0000);
    send_edge(32'd300000);
    send_edge(32'd0);
    send_edge(32'd227272);
    send_edge(32'd227273);
    send_edge(32'd15000000);
    send_edge(32'd14705882);
    send_flat(32'hFFFF_FFFF);
    send_edge(32'hFFFF_FF00 - stim_edge);
    send_edge(32'd400000);
    send_edge(32'd1);

    configure(32'd0, 16'hFFFF, 16'h0000, 1'b1);
    send_edge(32'd1);
    send_edge(32'd300000);

    configure(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b0);
    send_edge(32'hFFFF_FFFF);
    send_edge(32'd65536);
    send_edge(32'd65537);

    configure(RateNumReset, 16'd1000, 16'd1000, 1'b0);
    send_edge(32'd750000);
    send_edge(32'd800000);
    send_edge(32'd700000);

    configure(32'd1, 16'd2, 16'd0, 1'b0);
    send_edge(32'd1);
    send_edge(32'd2);
  endtask

  task automatic run_random_phase(input int ph);
    logic [DivW-1:0]   num;
    logic [SpeedW-1:0] up;
    logic [SpeedW-1:0] lo;
    logic [DivW-1:0]   half;
    int                pick;
    int                target;
    case (ph)
      0: begin
        num = RateNumReset;
        up  = UpperLimReset;
        lo  = LowerLimReset;
      end
      1: begin
        num = $urandom;
        up  = 16'($urandom_range(2, 65535));
        lo  = 16'($urandom_range(0, int'(up) - 2));
      end
      2: begin
        num = $urandom_range(1_000_000, 2_000_000_000);
        up  = 16'($urandom_range(0, 65535));
        lo  = 16'($urandom_range(int'(up), 65535));
      end
      default: begin
        num = $urandom_range(1_000_000, 2_000_000_000);
        up  = 16'($urandom_range(500, 65535));
        lo  = 16'($urandom_range(0, int'(up) / 2));
      end
    endcase
    configure(num, up, lo, 1'b0);
    for (int k = 0; k < 190; k++) begin
      if (k == 95) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (int'(up) > int'(lo) + 1) begin
          target = $urandom_range(int'(lo) + 1, int'(up) - 1);
          half = num / target;
          if (half == '0) half = 32'd1;
        end else begin
          half = $urandom;
        end
        send_edge(half);
      end else if (pick < 80) begin
        send_flat($urandom);
      end else if (pick < 85) begin
        send_edge(32'd0);
      end else if (pick < 95) begin
        send_edge($urandom);
      end else begin
        half = (up == '0) ? 32'd1 : num / up;
        send_edge(half);
      end
    end
  endtask

  initial begin
    int stall;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tdata);
      taken++;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= RegRateNum;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 6; ph++) run_random_phase(ph);
    wait_idle();
    repeat (40) @(posedge clk);
    $display("Streamed %0d tachometer samples with %0d level changes under %0d register settings;",
             board.samples, board.edges, settings + 1);
    $display("%0d speed readings entered the averaging window and %0d results were checked.",
             board.accepts, board.results);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/ftrma_pkg.sv
sv/ftrma_div.sv
sv/ftrma_datapath.sv
sv/ftrma_ctrl.sv
sv/fan_tacho_rpm_moving_average_top.sv
test/fan_tacho_rpm_moving_average_top_test.sv
